>>> sv/ppi_pkg.sv
// ---------------------------------------------------------------------------
// ppi_pkg: shared types, codes and drive helpers
// Register state, beat payloads and control word fields for the parallel
// port interface (mode 0).
// ---------------------------------------------------------------------------
package ppi_pkg;

   // Access kind carried by the command field
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Register map
   typedef enum logic [1:0] {
      ADDR_PORT_A  = 2'd0,
      ADDR_PORT_B  = 2'd1,
      ADDR_PORT_C  = 2'd2,
      ADDR_CONTROL = 2'd3
   } ppi_addr_type;

   // Control word after reset: mode set, all ports input
   localparam logic [7:0] CW_RESET = 8'h9b;

   // Control word bits (set = input direction)
   localparam int CW_MODE_SET_BIT = 7;
   localparam int CW_A_IN_BIT     = 4;
   localparam int CW_CH_IN_BIT    = 3;
   localparam int CW_B_IN_BIT     = 1;
   localparam int CW_CL_IN_BIT    = 0;

   // Bit set/reset command fields
   localparam int BSR_SEL_MSB = 3;
   localparam int BSR_SEL_LSB = 1;
   localparam int BSR_VAL_BIT = 0;

   typedef struct packed {
      logic [7:0] latch_a;
      logic [7:0] latch_b;
      logic [7:0] latch_c;
      logic [7:0] control_word;
      logic [7:0] last_a_drive;
      logic [7:0] last_c_drive;
   } ppi_state_type;

   typedef struct packed {
      logic       command;
      logic [1:0] port_address;
      logic [7:0] write_data;
      logic [7:0] port_a_pins;
      logic [7:0] port_b_pins;
      logic [7:0] port_c_pins;
   } ppi_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] port_a_drive;
      logic [7:0] port_b_drive;
      logic [7:0] port_c_drive;
      logic       port_a_changed;
      logic       port_c_changed;
   } ppi_rsp_type;

   function automatic logic [7:0] drive_a(input ppi_state_type s);
      return s.control_word[CW_A_IN_BIT] ? 8'h00 : s.latch_a;
   endfunction

   function automatic logic [7:0] drive_b(input ppi_state_type s);
      return s.control_word[CW_B_IN_BIT] ? 8'h00 : s.latch_b;
   endfunction

   function automatic logic [7:0] drive_c(input ppi_state_type s);
      logic [3:0] lo;
      logic [3:0] hi;
      lo = s.control_word[CW_CL_IN_BIT] ? 4'h0 : s.latch_c[3:0];
      hi = s.control_word[CW_CH_IN_BIT] ? 4'h0 : s.latch_c[7:4];
      return {hi, lo};
   endfunction

endpackage

>>> sv/ppi_if.sv
// ---------------------------------------------------------------------------
// ppi_req_if / ppi_rsp_if: valid/ready channels
// Access beats in, result beats out.
// ---------------------------------------------------------------------------
interface ppi_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [1:0] port_address;
   logic [7:0] write_data;
   logic [7:0] port_a_pins;
   logic [7:0] port_b_pins;
   logic [7:0] port_c_pins;

   modport source(output valid, command, port_address, write_data,
                  port_a_pins, port_b_pins, port_c_pins, input ready);
   modport sink(input valid, command, port_address, write_data,
                port_a_pins, port_b_pins, port_c_pins, output ready);
endinterface

interface ppi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [7:0] port_a_drive;
   logic [7:0] port_b_drive;
   logic [7:0] port_c_drive;
   logic       port_a_changed;
   logic       port_c_changed;

   modport source(output valid, read_data, port_a_drive, port_b_drive,
                  port_c_drive, port_a_changed, port_c_changed, input ready);
   modport sink(input valid, read_data, port_a_drive, port_b_drive,
                port_c_drive, port_a_changed, port_c_changed, output ready);
endinterface

>>> sv/parallel_port_interface_mode0.sv
// ---------------------------------------------------------------------------
// parallel_port_interface_mode0: three-port parallel interface, mode 0
// The result beat is registered: it is presented in the cycle after its access beat is accepted.
// Throughput one access per cycle while the result side is not stalling; the result register decouples the sides.
// Synchronous active-high reset: latches and last drives to 0, control word
// to 0x9b (all ports input), result register empty.
// ---------------------------------------------------------------------------
module parallel_port_interface_mode0 import ppi_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   ppi_req_if.sink   req_chan,
   ppi_rsp_if.source rsp_chan
);

   // Architectural register file: port latches, control word and the drive
   // values last reported after a write (for the change flags).
   ppi_state_type state_ff;
   ppi_state_type state_in;

   // Result register
   logic        rsp_valid_ff;
   ppi_rsp_type rsp_data_ff;
   ppi_rsp_type rsp_in;

   ppi_req_type req_beat;
   logic        req_accept;

   // Gather the access beat into one payload word
   assign req_beat.command      = req_chan.command;
   assign req_beat.port_address = req_chan.port_address;
   assign req_beat.write_data   = req_chan.write_data;
   assign req_beat.port_a_pins  = req_chan.port_a_pins;
   assign req_beat.port_b_pins  = req_chan.port_b_pins;
   assign req_beat.port_c_pins  = req_chan.port_c_pins;

   // Take a new beat whenever the result register is empty or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // All decode, the write update and change detection happen in one pass
   ppi_core u_core (
      .state    (state_ff),
      .req      (req_beat),
      .state_in (state_in),
      .rsp_in   (rsp_in)
   );

   // Control state: advance the register state only on an accepted beat; result valid also clears when drained
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.latch_a      <= 8'h00;
         state_ff.latch_b      <= 8'h00;
         state_ff.latch_c      <= 8'h00;
         state_ff.control_word <= CW_RESET;
         state_ff.last_a_drive <= 8'h00;
         state_ff.last_c_drive <= 8'h00;
         rsp_valid_ff          <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (req_accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: load with the accepted beat, hold while stalled
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.read_data      = rsp_data_ff.read_data;
   assign rsp_chan.port_a_drive   = rsp_data_ff.port_a_drive;
   assign rsp_chan.port_b_drive   = rsp_data_ff.port_b_drive;
   assign rsp_chan.port_c_drive   = rsp_data_ff.port_c_drive;
   assign rsp_chan.port_a_changed = rsp_data_ff.port_a_changed;
   assign rsp_chan.port_c_changed = rsp_data_ff.port_c_changed;

   // A read never reports a drive change
   a_read_no_change: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_chan.command == CMD_READ) |=>
         rsp_valid_ff && !rsp_data_ff.port_a_changed && !rsp_data_ff.port_c_changed)
      else $error("read beat reported a drive change");

   // A write returns zero read data
   a_write_zero_data: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_chan.command == CMD_WRITE) |=>
         rsp_valid_ff && (rsp_data_ff.read_data == 8'h00))
      else $error("write beat returned nonzero read data");

   // After a write the tracked drives match what was reported
   a_write_tracks_drive: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_chan.command == CMD_WRITE) |=>
         (state_ff.last_a_drive == rsp_data_ff.port_a_drive) &&
         (state_ff.last_c_drive == rsp_data_ff.port_c_drive))
      else $error("tracked drive differs from reported drive");

   // Architectural state only moves on an accepted beat
   a_state_stable: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("register state moved without an access");

endmodule

>>> sv/ppi_core.sv
// ---------------------------------------------------------------------------
// ppi_core: access decode and next-state logic
// Read mux, latch/control writes, bit set/reset and change detection.
// ---------------------------------------------------------------------------
module ppi_core import ppi_pkg::*; (
   input  ppi_state_type state,
   input  ppi_req_type   req,
   output ppi_state_type state_in,
   output ppi_rsp_type   rsp_in
);

   logic [7:0] new_a_drive;
   logic [7:0] new_c_drive;
   logic [7:0] c_read;

   // mix pins and latch per port C nibble
   assign c_read = {state.control_word[CW_CH_IN_BIT] ? req.port_c_pins[7:4]
                                                      : state.latch_c[7:4],
                    state.control_word[CW_CL_IN_BIT] ? req.port_c_pins[3:0]
                                                      : state.latch_c[3:0]};

   always_comb begin
      state_in    = state;
      rsp_in      = '0;
      new_a_drive = 8'h00;
      new_c_drive = 8'h00;
      if (req.command == CMD_READ) begin
         unique case (req.port_address)
            ADDR_PORT_A: begin
               rsp_in.read_data = state.control_word[CW_A_IN_BIT] ? req.port_a_pins
                                                                  : state.latch_a;
            end
            ADDR_PORT_B: begin
               rsp_in.read_data = state.control_word[CW_B_IN_BIT] ? req.port_b_pins
                                                                  : state.latch_b;
            end
            ADDR_PORT_C: begin
               rsp_in.read_data = c_read;
            end
            default: begin
               rsp_in.read_data = state.control_word;
            end
         endcase
      end else begin
         unique case (req.port_address)
            ADDR_PORT_A: state_in.latch_a = req.write_data;
            ADDR_PORT_B: state_in.latch_b = req.write_data;
            ADDR_PORT_C: state_in.latch_c = req.write_data;
            default: begin
               if (req.write_data[CW_MODE_SET_BIT]) begin
                  state_in.control_word = req.write_data;
               end else begin
                  state_in.latch_c[req.write_data[BSR_SEL_MSB:BSR_SEL_LSB]] =
                     req.write_data[BSR_VAL_BIT];
               end
            end
         endcase
         new_a_drive             = drive_a(state_in);
         new_c_drive             = drive_c(state_in);
         rsp_in.port_a_changed   = (new_a_drive != state.last_a_drive);
         rsp_in.port_c_changed   = (new_c_drive != state.last_c_drive);
         state_in.last_a_drive   = new_a_drive;
         state_in.last_c_drive   = new_c_drive;
      end
      rsp_in.port_a_drive = drive_a(state_in);
      rsp_in.port_b_drive = drive_b(state_in);
      rsp_in.port_c_drive = drive_c(state_in);
   end

endmodule

>>> verif/port_access_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// port_access_checker: scoreboard for the mode 0 parallel port interface
// Watches the access and result channels, keeps its own copy of the port
// latches and control word, and compares every result beat field by field.
// ---------------------------------------------------------------------------
module port_access_checker import ppi_pkg::*; (
   input  logic clock,
   input  logic reset,
   ppi_req_if   req_mon,
   ppi_rsp_if   rsp_mon,
   output int   errors,
   output int   outstanding
);

   logic [7:0] lat_a, lat_b, lat_c, ctrl, prev_a, prev_c;
   ppi_rsp_type pending_port_rsp[$];
   int mismatch_count;

   assign errors      = mismatch_count;
   assign outstanding = pending_port_rsp.size();

   function automatic logic [7:0] a_out();
      return ctrl[CW_A_IN_BIT] ? 8'h00 : lat_a;
   endfunction

   function automatic logic [7:0] b_out();
      return ctrl[CW_B_IN_BIT] ? 8'h00 : lat_b;
   endfunction

   function automatic logic [7:0] c_out();
      logic [7:0] v;
      v = lat_c;
      if (ctrl[CW_CL_IN_BIT]) v[3:0] = 4'h0;
      if (ctrl[CW_CH_IN_BIT]) v[7:4] = 4'h0;
      return v;
   endfunction

   // Apply one access to the shadow state and return the result it must give.
   function automatic ppi_rsp_type predict_port_access(input ppi_req_type acc);
      ppi_rsp_type r;
      logic [7:0] sel;
      r = '0;
      if (acc.command == CMD_WRITE) begin
         case (ppi_addr_type'(acc.port_address))
            ADDR_PORT_A: lat_a = acc.write_data;
            ADDR_PORT_B: lat_b = acc.write_data;
            ADDR_PORT_C: lat_c = acc.write_data;
            default: begin
               if (acc.write_data[CW_MODE_SET_BIT]) begin
                  ctrl = acc.write_data;
               end else begin
                  sel = 8'h01 << acc.write_data[BSR_SEL_MSB:BSR_SEL_LSB];
                  if (acc.write_data[BSR_VAL_BIT]) lat_c = lat_c | sel;
                  else lat_c = lat_c & ~sel;
               end
            end
         endcase
         r.port_a_changed = (a_out() != prev_a);
         r.port_c_changed = (c_out() != prev_c);
         prev_a = a_out();
         prev_c = c_out();
      end else begin
         case (ppi_addr_type'(acc.port_address))
            ADDR_PORT_A: r.read_data = ctrl[CW_A_IN_BIT] ? acc.port_a_pins : lat_a;
            ADDR_PORT_B: r.read_data = ctrl[CW_B_IN_BIT] ? acc.port_b_pins : lat_b;
            ADDR_PORT_C: begin
               r.read_data[3:0] = ctrl[CW_CL_IN_BIT] ? acc.port_c_pins[3:0] : lat_c[3:0];
               r.read_data[7:4] = ctrl[CW_CH_IN_BIT] ? acc.port_c_pins[7:4] : lat_c[7:4];
            end
            default: r.read_data = ctrl;
         endcase
      end
      r.port_a_drive = a_out();
      r.port_b_drive = b_out();
      r.port_c_drive = c_out();
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [7:0] exp_v,
                                       input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      ppi_req_type acc;
      ppi_rsp_type got;
      ppi_rsp_type exp_r;
      if (reset) begin
         lat_a  = 8'h00;
         lat_b  = 8'h00;
         lat_c  = 8'h00;
         ctrl   = CW_RESET;
         prev_a = 8'h00;
         prev_c = 8'h00;
         pending_port_rsp.delete();
      end else begin
         // retire the result first: it belongs to an older access
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{read_data: rsp_mon.read_data, port_a_drive: rsp_mon.port_a_drive,
                    port_b_drive: rsp_mon.port_b_drive, port_c_drive: rsp_mon.port_c_drive,
                    port_a_changed: rsp_mon.port_a_changed,
                    port_c_changed: rsp_mon.port_c_changed};
            if (pending_port_rsp.size() == 0) begin
               mismatch_count++;
               $display("%0t: result beat with no access pending, expected none, actual %h",
                        $time, got);
            end else begin
               exp_r = pending_port_rsp.pop_front();
               check_field("read_data", exp_r.read_data, got.read_data);
               check_field("port_a_drive", exp_r.port_a_drive, got.port_a_drive);
               check_field("port_b_drive", exp_r.port_b_drive, got.port_b_drive);
               check_field("port_c_drive", exp_r.port_c_drive, got.port_c_drive);
               check_field("port_a_changed", 8'(exp_r.port_a_changed), 8'(got.port_a_changed));
               check_field("port_c_changed", 8'(exp_r.port_c_changed), 8'(got.port_c_changed));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            acc = '{command: req_mon.command, port_address: req_mon.port_address,
                    write_data: req_mon.write_data, port_a_pins: req_mon.port_a_pins,
                    port_b_pins: req_mon.port_b_pins, port_c_pins: req_mon.port_c_pins};
            pending_port_rsp.push_back(predict_port_access(acc));
         end
      end
   end

   initial mismatch_count = 0;

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: top level for the mode 0 parallel port interface
// Drives directed and random bus accesses with random gaps and result
// back-pressure, including one long hold-off; the checker predicts and
// compares every result beat.
// ---------------------------------------------------------------------------
module testbench;
   import ppi_pkg::*;

   localparam int RANDOM_ACCESSES = 1750;

   logic clock;
   logic reset;
   int   error_count;
   int   pending_count;
   int   beats_sent;
   bit   steady;      // no idling on either side while set

   ppi_req_if req_bus();
   ppi_rsp_if rsp_bus();

   parallel_port_interface_mode0 DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   port_access_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .errors      (error_count),
      .outstanding (pending_count)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Offer one access beat and hold it until the block takes it. Called at a
   // rising edge; may first drop valid for a short random gap.
   task automatic send_access(input logic cmd, input ppi_addr_type addr,
                              input logic [7:0] data, input logic [7:0] pins_a,
                              input logic [7:0] pins_b, input logic [7:0] pins_c);
      if (!steady && $urandom_range(0, 99) < 20) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.port_address <= addr;
      req_bus.write_data   <= data;
      req_bus.port_a_pins  <= pins_a;
      req_bus.port_b_pins  <= pins_b;
      req_bus.port_c_pins  <= pins_c;
      do @(posedge clock); while (!req_bus.ready);
      beats_sent++;
   endtask

   // Pick a random access. Writes to the control address split between
   // mode sets and single-bit set/reset so the direction mix keeps moving.
   task automatic send_random_access();
      logic         cmd;
      ppi_addr_type addr;
      logic [7:0]   data;
      logic [7:0]   pins[3];
      cmd  = 1'($urandom_range(0, 1));
      addr = ppi_addr_type'($urandom_range(0, 3));
      data = 8'($urandom_range(0, 255));
      if (cmd == CMD_WRITE && addr == ADDR_CONTROL && $urandom_range(0, 1))
         data[CW_MODE_SET_BIT] = 1'b1;
      foreach (pins[i]) begin
         case ($urandom_range(0, 9))
            0:       pins[i] = 8'h00;
            1:       pins[i] = 8'hff;
            default: pins[i] = 8'($urandom_range(0, 255));
         endcase
      end
      send_access(cmd, addr, data, pins[0], pins[1], pins[2]);
   endtask

   // Result side: random stalls, one long hold-off while the sender keeps
   // pushing so the result register fills and the access side backs up.
   initial begin
      int hold;
      bit held_once;
      hold      = 0;
      held_once = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!held_once && beats_sent >= 500) begin
            held_once = 1'b1;
            hold      = 240;
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 20);
         end
      end
   end

   initial begin
      int drain;
      beats_sent = 0;
      steady     = 1'b0;
      drain      = 0;

      // Hold every input at a known value through reset
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_READ;
      req_bus.port_address <= ADDR_PORT_A;
      req_bus.write_data   <= 8'h00;
      req_bus.port_a_pins  <= 8'h00;
      req_bus.port_b_pins  <= 8'h00;
      req_bus.port_c_pins  <= 8'h00;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset every port is input: reads return the pins
      send_access(CMD_READ,  ADDR_CONTROL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_A,  8'h00, 8'hff, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_B,  8'h00, 8'h00, 8'hff, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_C,  8'h00, 8'h00, 8'h00, 8'hff);
      // Latch writes while input: drives stay 0, no change flags
      send_access(CMD_WRITE, ADDR_PORT_A,  8'hff, 8'h00, 8'h00, 8'h00);
      send_access(CMD_WRITE, ADDR_PORT_B,  8'hff, 8'h00, 8'h00, 8'h00);
      send_access(CMD_WRITE, ADDR_PORT_C,  8'hff, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_A,  8'h00, 8'h5a, 8'h00, 8'h00);
      // Mode set to all outputs: latches appear, A and C flag a change
      send_access(CMD_WRITE, ADDR_CONTROL, 8'h80, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_A,  8'h00, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_B,  8'h00, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_C,  8'h00, 8'h00, 8'h00, 8'h00);
      // Single-bit clear and set on port C; control word stays as is
      send_access(CMD_WRITE, ADDR_CONTROL, 8'h0e, 8'h00, 8'h00, 8'h00);
      send_access(CMD_WRITE, ADDR_CONTROL, 8'h00, 8'h00, 8'h00, 8'h00);
      send_access(CMD_WRITE, ADDR_CONTROL, 8'h0f, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_CONTROL, 8'h00, 8'h00, 8'h00, 8'h00);
      // Split port C: high nibble input, then low nibble input
      send_access(CMD_WRITE, ADDR_CONTROL, 8'h88, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_C,  8'h00, 8'h00, 8'h00, 8'ha5);
      send_access(CMD_WRITE, ADDR_CONTROL, 8'h81, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_C,  8'h00, 8'h00, 8'h00, 8'ha5);
      // Write of equal data: no change flag; then new data flags a change
      send_access(CMD_WRITE, ADDR_PORT_A,  8'hff, 8'h00, 8'h00, 8'h00);
      send_access(CMD_WRITE, ADDR_PORT_A,  8'h00, 8'h00, 8'h00, 8'h00);
      // Back to the reset word: drives drop to 0, latches kept
      send_access(CMD_WRITE, ADDR_CONTROL, 8'h9b, 8'h00, 8'h00, 8'h00);
      send_access(CMD_WRITE, ADDR_CONTROL, 8'hff, 8'h00, 8'h00, 8'h00);
      send_access(CMD_READ,  ADDR_PORT_B,  8'h00, 8'h00, 8'h3c, 8'h00);

      // Random traffic, with one stretch where neither side idles
      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         steady = (n >= 900 && n < 1200);
         send_random_access();
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      // Drain outstanding results, then allow the pipeline to settle
      while (pending_count != 0 && drain < 2000) begin
         @(posedge clock);
         drain++;
      end
      repeat (4) @(posedge clock);

      if (pending_count != 0)
         $display("%0t: %0d result beats never arrived", $time, pending_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
